FILE: rtl/sst_pkg.sv
// Shared types, sizes and operation codes of the scoped symbol table.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

    localparam int DEPTH      = 256;
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int FUNC_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SHD_W      = $clog2(DEPTH);
    localparam int GROUP_SIZE = 16;
    localparam int N_GROUPS   = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [FUNC_W-1:0] FN_ENTER  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FN_POP    = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVF   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [SHD_W-1:0] SHD_ONE = SHD_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // One binding as it sits in a cell. The shadow field counts the newer
    // live bindings that carry the same key; zero means it is visible.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [SHD_W-1:0] shadow;
    } t_entry;

    // Broadcast to all cells: shift direction and the key that moves.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] value;
    } t_hit;

endpackage

`default_nettype wire

FILE: rtl/sst_cell.sv
// One stack cell of the scoped symbol table: holds a binding, shifts with
// its neighbors on enter and pop, and matches the lookup key. Uses sst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sst_cell (
    input  wire logic                        i_clk,
    input  wire sst_pkg::t_cell_ctl          i_ctl,
    input  wire logic                        i_head,
    input  wire logic                        i_live,
    input  wire sst_pkg::t_entry             i_from_up,
    input  wire sst_pkg::t_entry             i_from_down,
    input  wire logic [sst_pkg::KEY_W-1:0]   i_query,
    output sst_pkg::t_entry                  o_entry,
    output sst_pkg::t_hit                    o_hit
);

    sst_pkg::t_entry r_entry;
    sst_pkg::t_entry n_entry;
    sst_pkg::t_hit   r_hit;
    sst_pkg::t_hit   n_hit;

    // An older binding of the entered key gains one shadow; the bindings of
    // the popped key lose one as the newest of them leaves the stack.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            n_entry = i_from_up;
            if (!i_head && (i_from_up.key == i_ctl.key)) begin
                n_entry.shadow = i_from_up.shadow + sst_pkg::SHD_ONE;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_from_down;
            if (i_from_down.key == i_ctl.key) begin
                n_entry.shadow = i_from_down.shadow - sst_pkg::SHD_ONE;
            end
        end
    end

    always_comb begin
        n_hit.found = i_live && (r_entry.key == i_query) && (r_entry.shadow == '0);
        n_hit.value = n_hit.found ? r_entry.value : '0;
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_hit   <= n_hit;
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

FILE: rtl/sst_or_group.sv
// Registered merge of the lookup hits of one group of cells. At most one
// cell of the whole stack hits, so a plain OR picks it. Uses sst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sst_or_group (
    input  wire logic           i_clk,
    input  wire sst_pkg::t_hit  i_hits [sst_pkg::GROUP_SIZE],
    output sst_pkg::t_hit       o_sum
);

    sst_pkg::t_hit r_sum;
    sst_pkg::t_hit n_sum;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < sst_pkg::GROUP_SIZE; i++) begin
            n_sum.found = n_sum.found | i_hits[i].found;
            n_sum.value = n_sum.value | i_hits[i].value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

FILE: rtl/scoped_symbol_table_unit.sv
// Top level of the scoped symbol table: the row of stack cells, the hit
// merge tree and the request sequencer. Uses sst_pkg, sst_cell, sst_or_group.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A request (func, key, bind_value) is taken on the input channel when
// i_in_valid is high and o_in_stall is low; one result (found, value_out,
// key_out, status) leaves on the output channel when o_out_valid is high
// and i_out_stall is low.
// Enter, pop and the unused function code finish in the cycle they are
// taken: the result is in the output register in the next cycle, and the
// next request can be taken right away. In a lookup the key is registered,
// every cell compares it in parallel, one level of registered OR groups
// merges the hits and the last level loads the output register once it is
// free. The lookup length is set by the depth of that merge tree, not by
// the number of bindings.
// Reset empties the stack at once by clearing the binding count; cells
// above the count are never read, so no clearing pass is needed.
// While the receiver stalls, the held result stays in place and the block
// takes no new request, since every request produces a result.

module scoped_symbol_table_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [sst_pkg::FUNC_W-1:0]   i_func,
    input  wire logic [sst_pkg::KEY_W-1:0]    i_key,
    input  wire logic [sst_pkg::VAL_W-1:0]    i_bind_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_found,
    output logic [sst_pkg::VAL_W-1:0]         o_value_out,
    output logic [sst_pkg::KEY_W-1:0]         o_key_out,
    output logic [sst_pkg::STAT_W-1:0]        o_status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_GRP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    localparam int PAD = sst_pkg::N_GROUPS * sst_pkg::GROUP_SIZE;

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [sst_pkg::CNT_W-1:0]  r_count;
    logic [sst_pkg::CNT_W-1:0]  n_count;
    logic [sst_pkg::KEY_W-1:0]  r_query;
    logic [sst_pkg::KEY_W-1:0]  n_query;

    logic                       r_out_valid;
    logic                       n_out_valid;
    logic                       r_out_found;
    logic                       n_out_found;
    logic [sst_pkg::VAL_W-1:0]  r_out_value;
    logic [sst_pkg::VAL_W-1:0]  n_out_value;
    logic [sst_pkg::KEY_W-1:0]  r_out_key;
    logic [sst_pkg::KEY_W-1:0]  n_out_key;
    logic [sst_pkg::STAT_W-1:0] r_out_status;
    logic [sst_pkg::STAT_W-1:0] n_out_status;

    logic                       w_accept;
    logic                       w_slot_free;
    logic                       w_full;
    logic                       w_empty;
    sst_pkg::t_cell_ctl         w_ctl;
    sst_pkg::t_entry            w_head_entry;
    sst_pkg::t_entry            w_entry [sst_pkg::DEPTH];
    logic                       w_live  [sst_pkg::DEPTH];
    sst_pkg::t_hit              w_hit   [PAD];
    sst_pkg::t_hit              w_group [sst_pkg::N_GROUPS];
    sst_pkg::t_hit              w_total;

    // The output register is free when empty or when its result is being
    // taken in this cycle.
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !w_slot_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_full      = (r_count == sst_pkg::CNT_FULL);
    assign w_empty     = (r_count == '0);

    // Cell 0 is the top of the stack. An enter shifts every binding one
    // cell down and puts the new one on top; a pop shifts them up. For a
    // pop the broadcast key is the leaving binding's key.
    always_comb begin
        w_ctl.push = w_accept && (i_func == sst_pkg::FN_ENTER) && !w_full;
        w_ctl.pop  = w_accept && (i_func == sst_pkg::FN_POP) && !w_empty;
        w_ctl.key  = w_ctl.push ? i_key : w_entry[0].key;
        w_head_entry.key    = i_key;
        w_head_entry.value  = i_bind_value;
        w_head_entry.shadow = '0;
    end

    for (genvar i = 0; i < sst_pkg::DEPTH; i++) begin : g_cell
        localparam logic [sst_pkg::CNT_W-1:0] IDX = sst_pkg::CNT_W'(i);
        sst_pkg::t_entry w_up;
        sst_pkg::t_entry w_down;

        if (i == 0) begin : g_top
            assign w_up = w_head_entry;
        end else begin : g_mid
            assign w_up = w_entry[i-1];
        end
        if (i == sst_pkg::DEPTH - 1) begin : g_bot
            assign w_down = w_entry[i];
        end else begin : g_above
            assign w_down = w_entry[i+1];
        end

        assign w_live[i] = (IDX < r_count);

        sst_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_head      ((i == 0) ? 1'b1 : 1'b0),
            .i_live      (w_live[i]),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .i_query     (r_query),
            .o_entry     (w_entry[i]),
            .o_hit       (w_hit[i])
        );
    end

    for (genvar i = sst_pkg::DEPTH; i < PAD; i++) begin : g_pad
        assign w_hit[i] = '0;
    end

    for (genvar g = 0; g < sst_pkg::N_GROUPS; g++) begin : g_group
        sst_pkg::t_hit w_slice [sst_pkg::GROUP_SIZE];
        for (genvar j = 0; j < sst_pkg::GROUP_SIZE; j++) begin : g_lane
            assign w_slice[j] = w_hit[g * sst_pkg::GROUP_SIZE + j];
        end
        sst_or_group u_group (
            .i_clk  (i_clk),
            .i_hits (w_slice),
            .o_sum  (w_group[g])
        );
    end

    // Shadow counts leave at most one visible match, so the last level is
    // also a plain OR.
    always_comb begin
        w_total = '0;
        for (int g = 0; g < sst_pkg::N_GROUPS; g++) begin
            w_total.found = w_total.found | w_group[g].found;
            w_total.value = w_total.value | w_group[g].value;
        end
    end

    // Request sequencer and output register.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_query      = r_query;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_found  = r_out_found;
        n_out_value  = r_out_value;
        n_out_key    = r_out_key;
        n_out_status = r_out_status;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_found  = 1'b0;
                    n_out_value  = '0;
                    n_out_key    = '0;
                    n_out_status = sst_pkg::STAT_OK;
                    case (i_func)
                        sst_pkg::FN_ENTER: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_out_status = sst_pkg::STAT_OVF;
                            end else begin
                                n_count = r_count + sst_pkg::CNT_ONE;
                            end
                        end
                        sst_pkg::FN_LOOKUP: begin
                            n_query = i_key;
                            n_state = S_CMP;
                        end
                        sst_pkg::FN_POP: begin
                            n_out_valid = 1'b1;
                            if (w_empty) begin
                                n_out_status = sst_pkg::STAT_EMPTY;
                            end else begin
                                n_out_key = w_entry[0].key;
                                n_count   = r_count - sst_pkg::CNT_ONE;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_CMP: begin
                n_state = S_GRP;
            end
            S_GRP: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = w_total.found;
                    n_out_value  = w_total.value;
                    n_out_key    = '0;
                    n_out_status = sst_pkg::STAT_OK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query      <= n_query;
        r_out_found  <= n_out_found;
        r_out_value  <= n_out_value;
        r_out_key    <= n_out_key;
        r_out_status <= n_out_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_value_out = r_out_value;
    assign o_key_out   = r_out_key;
    assign o_status    = r_out_status;

    // The binding count never passes the stack depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sst_pkg::CNT_FULL)
        else $error("binding count above stack depth");

    // A request is never taken while a lookup is in flight.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_accept)
        else $error("request taken during lookup");

    // An enter into a store with room adds exactly one binding.
    a_enter_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_func == sst_pkg::FN_ENTER) && !w_full)
        |=> (r_count == $past(r_count) + sst_pkg::CNT_ONE))
        else $error("enter did not grow the stack by one");

    // A pop of an empty store reports the empty error in the next cycle.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_func == sst_pkg::FN_POP) && w_empty)
        |=> (r_out_valid && (r_out_status == sst_pkg::STAT_EMPTY) && (r_count == '0)))
        else $error("pop of empty store not flagged");

endmodule

`default_nettype wire
